### design/b64d_pkg.sv
// shared types, constants and the character decode function of the base64 decoder
// no dependencies
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'd61;
  localparam logic [6:0] BAD_SEXTET = 7'd64;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LENGTH   = 2'd1,
    ST_BAD_CHAR = 2'd2
  } status_t;

  // one queued group: up to three bytes, or a status-only result when nbytes is 0
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            eos;
    status_t         status;
  } group_t;

  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] s;
    s = BAD_SEXTET;
    if (c >= 8'd65 && c <= 8'd90) begin
      s = 7'(c - 8'd65);
    end else if (c >= 8'd97 && c <= 8'd122) begin
      s = 7'(c - 8'd71);
    end else if (c >= 8'd48 && c <= 8'd57) begin
      s = 7'(c + 8'd4);
    end else if (c == 8'd43) begin
      s = 7'd62;
    end else if (c == 8'd47) begin
      s = 7'd63;
    end
    return s;
  endfunction

endpackage

### design/b64d_in_if.sv
// input channel of the base64 decoder: one character per transaction
// no dependencies
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

### design/b64d_out_if.sv
// output channel of the base64 decoder: one byte or status per transaction
// no dependencies
interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_string;
  logic [1:0] status;

  modport source (output valid, output data_byte, output byte_valid,
                  output end_of_string, output status, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input end_of_string, input status, output ready);
endinterface

### design/b64d_front.sv
// front end: accepts characters, tracks group position and errors, builds groups
// depends on b64d_pkg and b64d_in_if
module b64d_front import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  b64d_in_if.sink     in_ch,
  input  logic        q_full,
  output logic        push,
  output group_t      push_group
);

  logic [1:0]      pos;
  logic [2:0][6:0] held;
  logic            third_is_pad;
  logic            error_seen;

  logic [6:0] s;
  logic       pad;
  logic       err;
  logic       accept;
  logic [5:0] a, b, d, e;
  logic [1:0] cnt;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    s   = sextet_of(in_ch.char_in);
    pad = (in_ch.char_in == PAD_CHAR);
    err = error_seen;
    if (s == BAD_SEXTET && !pad) err = 1'b1;
    if (pad && pos < 2'd2) err = 1'b1;
    if (pad && pos == 2'd3 && !in_ch.last_char) err = 1'b1;
    if (pos == 2'd3 && third_is_pad && !pad) err = 1'b1;

    a = held[0][5:0];
    b = held[1][5:0];
    d = held[2][5:0];
    e = s[5:0];
    cnt = third_is_pad ? 2'd1 : (pad ? 2'd2 : 2'd3);

    push_group.bytes[0] = {a, b[5:4]};
    push_group.bytes[1] = {b[3:0], d[5:2]};
    push_group.bytes[2] = {d[1:0], e};
    push_group.nbytes   = cnt;
    push_group.eos      = in_ch.last_char;
    push_group.status   = ST_OK;
    if (in_ch.last_char) begin
      if (pos != 2'd3) begin
        push_group.nbytes = 2'd0;
        push_group.status = ST_LENGTH;
      end else if (err) begin
        push_group.nbytes = 2'd0;
        push_group.status = ST_BAD_CHAR;
      end
    end
    push = accept && ((pos == 2'd3 && !err) || in_ch.last_char);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= 2'd0;
      held         <= '0;
      third_is_pad <= 1'b0;
      error_seen   <= 1'b0;
    end else if (accept) begin
      if (in_ch.last_char) begin
        pos          <= 2'd0;
        held         <= '0;
        third_is_pad <= 1'b0;
        error_seen   <= 1'b0;
      end else begin
        case (pos)
          2'd0: held[0] <= s;
          2'd1: held[1] <= s;
          2'd2: begin
            held[2]      <= s;
            third_is_pad <= pad;
          end
          default: third_is_pad <= 1'b0;
        endcase
        pos        <= pos + 2'd1;
        error_seen <= err;
      end
    end
  end

endmodule

### design/b64d_queue.sv
// short group queue between the front and back ends
// depends on b64d_pkg
module b64d_queue import b64d_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  group_t push_group,
  input  logic   pop,
  output logic   full,
  output logic   not_empty,
  output group_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  group_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_group;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

### design/b64d_back.sv
// back end: splits queued groups into byte and status results, registered output
// depends on b64d_pkg and b64d_out_if
module b64d_back import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        not_empty,
  input  group_t      head,
  output logic        pop,
  b64d_out_if.source  out_ch
);

  logic [1:0] idx;
  logic [1:0] last_idx;
  logic       load;
  logic       at_last;
  logic [7:0] sel_byte;

  always_comb begin
    last_idx = (head.nbytes == 2'd0) ? 2'd0 : head.nbytes - 2'd1;
    at_last  = (idx == last_idx);
    load     = not_empty && (!out_ch.valid || out_ch.ready);
    pop      = load && at_last;
    case (idx)
      2'd0:    sel_byte = head.bytes[0];
      2'd1:    sel_byte = head.bytes[1];
      default: sel_byte = head.bytes[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= 2'd0;
      out_ch.valid <= 1'b0;
    end else begin
      if (load) begin
        out_ch.valid <= 1'b1;
        idx          <= at_last ? 2'd0 : idx + 2'd1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      if (head.nbytes == 2'd0) begin
        out_ch.data_byte  <= 8'd0;
        out_ch.byte_valid <= 1'b0;
      end else begin
        out_ch.data_byte  <= sel_byte;
        out_ch.byte_valid <= 1'b1;
      end
      out_ch.end_of_string <= head.eos && at_last;
      out_ch.status        <= head.status;
    end
  end

endmodule

### design/base64_stream_decoder_top.sv
// top level of the streaming base64 decoder
// depends on b64d_pkg, b64d_in_if, b64d_out_if, b64d_front, b64d_queue, b64d_back
//
// Usage:
//   in_ch carries one base64 character per transaction (char_in), with
//   last_char high on the final character of a string. out_ch carries one
//   result per transaction: a decoded byte (byte_valid high) or a status-only
//   result. end_of_string marks the final result of a string; status is then
//   ok, length error or invalid character. Bytes sent before an error status
//   should be dropped by the consumer.
// Timing:
//   one character is taken per cycle while the queue is not full. A group is
//   written into the queue, then its bytes leave the output register one per
//   cycle while out_ch is ready. Four characters give at most three results,
//   so the byte serializer keeps up with the input.
// Reset and stall:
//   synchronous rst clears group position, error flag, queue and output valid.
//   When out_ch stalls the output register holds, groups gather in a queue of
//   QUEUE_DEPTH entries, and in_ch.ready drops only when that queue is full.
module base64_stream_decoder_top import b64d_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  b64d_in_if.sink     in_ch,
  b64d_out_if.source  out_ch
);

  logic   q_full;
  logic   q_not_empty;
  logic   push;
  logic   pop;
  group_t push_group;
  group_t head;

  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_group (push_group)
  );

  b64d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (q_not_empty),
    .head      (head),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
